/* rtl/integer_to_radix_ascii_macros.svh */
// assertion macros shared by the checker files of the radix ascii converter
// depends on a clk and an active-low rst_n in the scope where a macro is used
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/itoa_pkg.sv */
// shared types, constants and functions of the radix ascii converter
// no dependencies
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IN_BITS    = 32;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] RADIX_MIN  = 8'd2;
    localparam logic [7:0] RADIX_MAX  = 8'd36;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A_OFS = 8'h57;

    typedef struct packed {
        logic                  bad;
        logic                  neg;
        logic [RADIX_W-1:0]    radix;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_STORE,
        B_SIGN,
        B_READ,
        B_EMIT,
        B_TERM
    } back_state_t;

    // digit value to its ascii character, 0-9 then a-z
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] dx;
        dx = {{(8 - DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(10))
        begin
            return CHAR_ZERO + dx;
        end
        return CHAR_A_OFS + dx;
    endfunction

endpackage

/* rtl/itoa_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/itoa_front.sv */
// front end: takes input items, checks the radix and forms sign and magnitude
// depends on itoa_pkg
module itoa_front
    import itoa_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IN_BITS-1:0] value,
    input  logic [7:0]         radix,
    input  logic               q_full,
    output logic               push,
    output item_t              item
);

    logic [VALUE_BITS-1:0] raw;
    logic                  neg;

    assign raw = value[VALUE_BITS-1:0];
    assign neg = raw[VALUE_BITS-1];

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        item.bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
        item.neg   = neg;
        item.radix = radix[RADIX_W-1:0];
        // two's complement magnitude, the most negative value maps onto itself unsigned
        item.mag   = neg ? (~raw + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : raw;
    end

endmodule

/* rtl/itoa_queue.sv */
// short item queue between the front end and the conversion engine
// depends on itoa_pkg
module itoa_queue
    import itoa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/itoa_back.sv */
// conversion engine: bit-serial divider, digit buffer sequencing, output register
// depends on itoa_pkg and itoa_ram
module itoa_back
    import itoa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] character,
    output logic       last
);

    back_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] work_reg, work_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic                  ov_reg, ov_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic               slot_free;
    logic               load;
    logic [7:0]         load_char;
    logic               load_last;
    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   rd_idx;
    logic [DIGIT_W-1:0] ram_rdata;
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W:0]   diff;
    logic               ge;
    logic               quot_zero;

    assign slot_free = !ov_reg || out_ready;
    assign trial     = {rem_reg, work_reg[VALUE_BITS-1]};
    assign diff      = trial - {1'b0, radix_reg};
    assign ge        = (trial >= {1'b0, radix_reg});
    assign quot_zero = (work_reg == '0);
    assign rd_idx    = IDX_W'(cnt_reg - 1'b1);

    itoa_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (rem_reg),
        .re    (ram_re),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.bad ? B_TERM : B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == IDX_W'(VALUE_BITS - 1))
                begin
                    state_next = B_STORE;
                end
            end
            B_STORE:
            begin
                if (!quot_zero)
                begin
                    state_next = B_DIV;
                end
                else
                begin
                    state_next = neg_reg ? B_SIGN : B_READ;
                end
            end
            B_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = (cnt_reg == CNT_W'(1)) ? B_TERM : B_READ;
                end
            end
            B_TERM:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        load      = 1'b0;
        load_char = CHAR_NUL;
        load_last = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                q_pop = q_valid;
            end
            B_STORE:
            begin
                ram_we = 1'b1;
            end
            B_SIGN:
            begin
                load      = slot_free;
                load_char = CHAR_MINUS;
            end
            B_READ:
            begin
                ram_re = 1'b1;
            end
            B_EMIT:
            begin
                load      = slot_free;
                load_char = digit_char(ram_rdata);
            end
            B_TERM:
            begin
                load      = slot_free;
                load_last = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        work_next  = work_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        ov_next    = ov_reg && !out_ready;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    work_next  = q_item.mag;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    radix_next = q_item.radix;
                    neg_next   = q_item.neg;
                end
            end
            B_DIV:
            begin
                // one quotient bit per cycle, restoring
                rem_next  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
                work_next = {work_reg[VALUE_BITS-2:0], ge};
                step_next = step_reg + 1'b1;
            end
            B_STORE:
            begin
                cnt_next  = cnt_reg + 1'b1;
                rem_next  = '0;
                step_next = '0;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase

        if (load)
        begin
            ov_next   = 1'b1;
            char_next = load_char;
            last_next = load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign out_valid = ov_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

/* rtl/integer_to_radix_ascii.sv */
// top level of the signed integer to radix ascii converter
// depends on itoa_pkg, itoa_front, itoa_queue, itoa_back (and itoa_ram below it)
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_ready  | value (32b signed), radix (8b)
//  out     | out_valid / out_ready| character (8b), last (1b)
//
// each digit is worked out in the shared bit-serial divider
// (one quotient bit per cycle plus a buffer write), then each emitted
// digit takes a digit buffer read
// an out-of-range radix yields only the terminator
// reset is asynchronous, active low; the digit buffer is not cleared
// the front end keeps taking items into a two-entry queue, as long as it is
// not full, while the engine works or the output stalls
module integer_to_radix_ascii
    import itoa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IN_BITS-1:0] value,
    input  logic [7:0]         radix,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         character,
    output logic               last
);

    // front to queue
    logic  push;
    item_t push_item;
    logic  q_full;

    // queue to engine
    logic  q_valid;
    logic  q_pop;
    item_t q_head;

    // classifies the item: radix range, sign and magnitude
    itoa_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .radix    (radix),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    // decouples acceptance from conversion
    itoa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // divides out digits, then streams sign, digits and terminator (only the terminator for a bad radix)
    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule

/* rtl/itoa_checker.sv */
// port-level checks on the radix ascii converter, bound to the top level
// depends on itoa_pkg and integer_to_radix_ascii_macros.svh
`include "integer_to_radix_ascii_macros.svh"

module itoa_checker
    import itoa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [7:0]         character,
    input logic               last
);

    // a stalled result holds
    `ITOA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(character) && $stable(last), "stalled result changed")

    // the terminator is always a nul
    `ITOA_ASSERT_NOW(a_term_nul, out_valid && last, character == CHAR_NUL,
        "terminator is not nul")

    // every other character is a sign or a digit
    `ITOA_ASSERT_NOW(a_char_set, out_valid && !last,
        (character == CHAR_MINUS) ||
        (character >= 8'h30 && character <= 8'h39) ||
        (character >= 8'h61 && character <= 8'h7a), "illegal character")

    // a minus is always followed by a digit, never straight by the terminator
    `ITOA_ASSERT_NEXT(a_minus_digit, out_valid && out_ready && !last && character == CHAR_MINUS,
        !out_valid || (!last && character != CHAR_MINUS), "sign not followed by digit")

endmodule

bind integer_to_radix_ascii itoa_checker u_itoa_checker (.*);
